>>> rtl/multi_quadrature_encoder_decoder_macros.svh
// assertion macros for the multi quadrature encoder decoder
`ifndef MULTI_QUADRATURE_ENCODER_DECODER_MACROS_SVH
`define MULTI_QUADRATURE_ENCODER_DECODER_MACROS_SVH

`ifndef SYNTH
`define MQED_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("mqed assertion failed");
`define MQED_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("mqed assertion failed");
`else
`define MQED_ASSERT(lbl, prop)
`define MQED_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

>>> rtl/mqed_pkg.sv
// shared types and constants for the multi quadrature encoder decoder
package mqed_pkg;

    localparam int ENCODER_COUNT  = 5;
    localparam int PIN_BITS       = 5;
    localparam int SEL_W          = 3;
    localparam int DELTA_W        = 8;
    localparam int STEPS_W        = 6;
    localparam int INTERVAL_W     = 8;
    localparam int S_TDATA_W      = 24;
    localparam int M_TDATA_W      = 8;
    localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = 8'd100;

    typedef enum logic [1:0] {
        OP_TICK   = 2'd0,
        OP_READ   = 2'd1,
        OP_SWITCH = 2'd2,
        OP_INIT   = 2'd3
    } t_opcode;

    typedef struct packed {
        logic tick;
        logic init;
        logic consume;
        logic sample;
    } t_lane_ctrl;

endpackage

>>> rtl/multi_quadrature_encoder_decoder.sv
// top level: encoder lanes, switch sampler and result merge register
// a read or switch query shows its result in the cycle after the input beat
// one input beat per cycle while no recompute runs, no config write waits and the output is not stalled
// a config write recomputes tick count modulo interval bit-serially,
// with the input stalled; synchronous active-low reset clears all lanes,
// the tick counter and the output valid flag, interval resets to 100
`include "multi_quadrature_encoder_decoder_macros.svh"

module multi_quadrature_encoder_decoder #(
    parameter int ENCODER_COUNT = mqed_pkg::ENCODER_COUNT
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    // opcode, phase_a_levels, phase_b_levels, switch_levels, encoder_select
    input  logic [mqed_pkg::S_TDATA_W-1:0]      i_s_tdata,
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    // detent_steps, pressed
    output logic [mqed_pkg::M_TDATA_W-1:0]      o_m_tdata,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [mqed_pkg::INTERVAL_W-1:0]     i_cfg_data
);

    localparam int PB = mqed_pkg::PIN_BITS;

    mqed_pkg::t_opcode                      op;
    logic [PB-1:0]                          pin_a;
    logic [PB-1:0]                          pin_b;
    logic [PB-1:0]                          pin_sw;
    logic [mqed_pkg::SEL_W-1:0]             sel;
    logic                                   s_acc;
    logic                                   cfg_acc;
    logic                                   busy;
    logic                                   sample;
    mqed_pkg::t_lane_ctrl                   lane_ctrl [ENCODER_COUNT];
    logic [mqed_pkg::DELTA_W-1:0]           lane_delta [ENCODER_COUNT];
    logic                                   lane_sw [ENCODER_COUNT];
    logic                                   sel_hit;
    logic [mqed_pkg::DELTA_W-1:0]           sel_delta;
    logic                                   sel_sw;
    logic                                   has_result;
    logic                                   r_m_tvalid;
    logic                                   n_m_tvalid;
    logic [mqed_pkg::M_TDATA_W-1:0]         r_m_tdata;
    logic [mqed_pkg::M_TDATA_W-1:0]         n_m_tdata;
    logic [mqed_pkg::STEPS_W-1:0]           steps;
    logic                                   pressed;

    assign op     = mqed_pkg::t_opcode'(i_s_tdata[1:0]);
    assign pin_a  = i_s_tdata[6:2];
    assign pin_b  = i_s_tdata[11:7];
    assign pin_sw = i_s_tdata[16:12];
    assign sel    = i_s_tdata[19:17];

    // a pending config write takes the cycle, no input beat alongside it
    assign o_s_tready  = !busy && !i_cfg_valid && (!r_m_tvalid || i_m_tready);
    assign s_acc       = i_s_tvalid && o_s_tready;
    assign o_cfg_ready = !busy;
    assign cfg_acc     = i_cfg_valid && o_cfg_ready;

    mqed_sampler u_sampler (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_tick     (s_acc && (op == mqed_pkg::OP_TICK)),
        .i_cfg_we   (cfg_acc),
        .i_cfg_data (i_cfg_data),
        .o_sample   (sample),
        .o_busy     (busy)
    );

    for (genvar g = 0; g < ENCODER_COUNT; g++) begin : g_lane
        logic a_pin;
        logic b_pin;
        logic sw_pin;

        if (g < PB) begin : g_pin
            assign a_pin  = pin_a[g];
            assign b_pin  = pin_b[g];
            assign sw_pin = pin_sw[g];
        end else begin : g_nopin
            assign a_pin  = 1'b0;
            assign b_pin  = 1'b0;
            assign sw_pin = 1'b0;
        end

        assign lane_ctrl[g].tick    = s_acc && (op == mqed_pkg::OP_TICK);
        assign lane_ctrl[g].init    = s_acc && (op == mqed_pkg::OP_INIT);
        assign lane_ctrl[g].consume = s_acc && (op == mqed_pkg::OP_READ)
                                      && (int'(sel) == g);
        assign lane_ctrl[g].sample  = sample;

        mqed_lane u_lane (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctrl    (lane_ctrl[g]),
            .i_a       (a_pin),
            .i_b       (b_pin),
            .i_sw      (sw_pin),
            .o_delta   (lane_delta[g]),
            .o_pressed (lane_sw[g])
        );
    end

    // merge: pick the addressed lane
    always_comb begin
        sel_hit   = 1'b0;
        sel_delta = '0;
        sel_sw    = 1'b0;
        for (int i = 0; i < ENCODER_COUNT; i++) begin
            if (int'(sel) == i) begin
                sel_hit   = 1'b1;
                sel_delta = lane_delta[i];
                sel_sw    = lane_sw[i];
            end
        end
    end

    assign has_result = (op == mqed_pkg::OP_READ) || (op == mqed_pkg::OP_SWITCH);
    assign steps      = (sel_hit && (op == mqed_pkg::OP_READ))
                        ? sel_delta[mqed_pkg::DELTA_W-1:2] : '0;
    assign pressed    = sel_hit && (op == mqed_pkg::OP_SWITCH) && sel_sw;

    always_comb begin
        n_m_tvalid = r_m_tvalid;
        n_m_tdata  = r_m_tdata;
        if (s_acc && has_result) begin
            n_m_tvalid = 1'b1;
            n_m_tdata  = {1'b0, pressed, steps};
        end else if (i_m_tready) begin
            n_m_tvalid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_tvalid <= 1'b0;
        end else begin
            r_m_tvalid <= n_m_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_m_tdata <= n_m_tdata;
    end

    assign o_m_tvalid = r_m_tvalid;
    assign o_m_tdata  = r_m_tdata;

    `MQED_ASSERT(a_result_follows, (s_acc && has_result) |=> r_m_tvalid)
    `MQED_ASSERT(a_cfg_starts_recompute, cfg_acc |=> (busy && !o_s_tready))
    `MQED_ASSERT(a_steps_only_on_read, (s_acc && (op != mqed_pkg::OP_READ)) |=> (!r_m_tvalid || (r_m_tdata[mqed_pkg::STEPS_W-1:0] == '0)))

endmodule

>>> rtl/mqed_lane.sv
// one encoder lane: gray position tracking, step delta and switch sample
module mqed_lane (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  mqed_pkg::t_lane_ctrl            i_ctrl,
    input  logic                            i_a,
    input  logic                            i_b,
    input  logic                            i_sw,
    output logic [mqed_pkg::DELTA_W-1:0]    o_delta,
    output logic                            o_pressed
);

    logic [1:0]                         r_pos;
    logic [1:0]                         n_pos;
    logic [mqed_pkg::DELTA_W-1:0]       r_delta;
    logic [mqed_pkg::DELTA_W-1:0]       n_delta;
    logic                               r_sw;
    logic                               n_sw;
    logic [1:0]                         pos;
    logic [1:0]                         diff;

    assign pos  = {i_a, i_a ^ i_b};
    assign diff = r_pos - pos;

    always_comb begin
        n_pos   = r_pos;
        n_delta = r_delta;
        n_sw    = r_sw;
        if (i_ctrl.init) begin
            n_pos   = pos;
            n_delta = '0;
        end else if (i_ctrl.tick) begin
            if (diff[0]) begin
                n_pos   = pos;
                n_delta = diff[1] ? r_delta + 1'b1 : r_delta - 1'b1;
            end
            if (i_ctrl.sample) begin
                n_sw = ~i_sw;
            end
        end else if (i_ctrl.consume) begin
            n_delta = {{(mqed_pkg::DELTA_W-2){1'b0}}, r_delta[1:0]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_delta <= '0;
            r_sw    <= 1'b0;
        end else begin
            r_pos   <= n_pos;
            r_delta <= n_delta;
            r_sw    <= n_sw;
        end
    end

    assign o_delta   = r_delta;
    assign o_pressed = r_sw;

endmodule

>>> rtl/mqed_sampler.sv
// tick counter, sample interval register and tick-count remainder tracking
module mqed_sampler (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_tick,
    input  logic                                i_cfg_we,
    input  logic [mqed_pkg::INTERVAL_W-1:0]     i_cfg_data,
    output logic                                o_sample,
    output logic                                o_busy
);

    localparam int W = mqed_pkg::INTERVAL_W;

    logic [W-1:0]           r_tc;
    logic [W-1:0]           n_tc;
    logic [W-1:0]           r_interval;
    logic [W-1:0]           n_interval;
    logic [W-1:0]           r_phase;
    logic [W-1:0]           n_phase;
    logic [W-1:0]           r_shift;
    logic [W-1:0]           n_shift;
    logic [$clog2(W)-1:0]   r_cnt;
    logic [$clog2(W)-1:0]   n_cnt;
    logic                   r_busy;
    logic                   n_busy;
    logic [W-1:0]           tc_inc;
    logic [W:0]             phase_inc;
    logic [W:0]             period;
    logic [W:0]             trial;
    logic [W:0]             divisor;

    assign tc_inc    = r_tc + 1'b1;
    assign phase_inc = {1'b0, r_phase} + 1'b1;
    assign period    = {(r_interval == '0), r_interval};
    assign o_sample  = (tc_inc == '0) || (phase_inc == period);
    assign trial     = {r_phase, r_shift[W-1]};
    assign divisor   = {1'b0, r_interval};

    always_comb begin
        n_tc       = r_tc;
        n_interval = r_interval;
        n_phase    = r_phase;
        n_shift    = r_shift;
        n_cnt      = r_cnt;
        n_busy     = r_busy;
        if (i_cfg_we) begin
            n_interval = i_cfg_data;
            n_phase    = '0;
            n_shift    = r_tc;
            n_cnt      = '1;
            n_busy     = 1'b1;
        end else if (r_busy) begin
            // restoring remainder step, one tick-count bit per cycle
            n_phase = (trial >= divisor) ? W'(trial - divisor) : trial[W-1:0];
            n_shift = {r_shift[W-2:0], 1'b0};
            n_cnt   = r_cnt - 1'b1;
            n_busy  = (r_cnt != '0);
        end else if (i_tick) begin
            n_tc    = tc_inc;
            n_phase = o_sample ? '0 : phase_inc[W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tc       <= '0;
            r_interval <= mqed_pkg::INTERVAL_RESET;
            r_phase    <= '0;
            r_cnt      <= '0;
            r_busy     <= 1'b0;
        end else begin
            r_tc       <= n_tc;
            r_interval <= n_interval;
            r_phase    <= n_phase;
            r_cnt      <= n_cnt;
            r_busy     <= n_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_shift <= n_shift;
    end

    assign o_busy = r_busy;

endmodule
